### hdl/lcg_rg_pkg.sv
`timescale 1ns / 1ps

package lcg_rg_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned CELL_N  = WORD_W;  // one dividend bit per cell
  localparam int unsigned INDEX_W = 2;

  localparam logic [WORD_W-1:0] LCG_MUL    = 32'd19004983;
  localparam logic [WORD_W-1:0] LCG_ADD    = 32'd19004989;
  localparam logic [WORD_W-1:0] RESET_SEED = 32'd6089;
  localparam logic [WORD_W-1:0] RESET_MIN  = 32'd0;
  localparam logic [WORD_W-1:0] RESET_MAX  = 32'd10000;

  localparam logic [INDEX_W-1:0] REG_SEED = 2'd0;
  localparam logic [INDEX_W-1:0] REG_MIN  = 2'd1;
  localparam logic [INDEX_W-1:0] REG_MAX  = 2'd2;

  // One beat moving down the remainder chain.
  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] rem;   // partial remainder, below dsr whenever dsr is nonzero
    logic [WORD_W-1:0] dvd;   // dividend, rotated left one bit per cell
    logic [WORD_W-1:0] dsr;   // span = max - min
    logic [WORD_W-1:0] lo;    // lower bound
    logic              err;   // empty range
  } div_beat_t;

endpackage

### hdl/lcg_range_generator_top.sv
`timescale 1ns / 1ps
// Linear congruential random source with range reduction.
// Input channel (in_valid / in_ready / in_draw): each accepted beat with
// in_draw high advances the 32-bit state to state*19004983 + 19004989 and
// produces one result beat; a beat with in_draw low is taken and dropped.
// Result channel (out_valid / out_ready): out_value = min + state mod
// (max - min), out_raw_state = new state, out_range_error flags max <= min,
// in which case out_value is min.
// Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data):
// index 0 seed (also reloads the state), 1 min, 2 max; index 3 is ignored.
// cfg_ready is always high. Write registers only while no draw is in flight.
// Pipeline: the launch register loads at the accepting edge, then 32 remainder
// cells of one bit each and one output register carry the draw to out_valid.
// Throughput: one beat per cycle while the output is not stalled; the state
// update is a single multiply-add per cycle, and the cell chain is fully
// pipelined.
// Stall: when out_valid is high and out_ready low the whole chain holds and
// in_ready drops in the same cycle.
// Reset (rst_n low, synchronous): state = 6089, min = 0, max = 10000, all
// beats in flight are discarded.

module lcg_range_generator_top
  import lcg_rg_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_draw,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [WORD_W-1:0] out_value,
  output logic        [WORD_W-1:0] out_raw_state,
  output logic                     out_range_error,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic        [INDEX_W-1:0] cfg_index,
  input  logic        [WORD_W-1:0] cfg_data
);

  logic [WORD_W-1:0] state_r, state_nxt;
  logic [WORD_W-1:0] min_r, max_r;
  logic [WORD_W-1:0] lcg_next;
  logic [WORD_W-1:0] span;
  logic              range_err;
  logic              adv;
  logic              draw_fire;
  div_beat_t         launch_nxt, launch_r;
  div_beat_t         chain [0:CELL_N];

  logic                     out_valid_r;
  logic        [WORD_W-1:0] out_value_r;
  logic        [WORD_W-1:0] out_raw_r;
  logic                     out_err_r;
  logic        [WORD_W-1:0] last_value;

  // Advance everything whenever the output register is free or being taken.
  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;
  assign draw_fire = in_valid && adv && in_draw;

  // One multiply-add per draw; the product wraps mod 2^32.
  assign lcg_next = state_r * LCG_MUL + LCG_ADD;

  always_comb begin
    state_nxt = state_r;
    if (cfg_valid && cfg_index == REG_SEED) begin
      state_nxt = cfg_data;
    end else if (draw_fire) begin
      state_nxt = lcg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= RESET_SEED;
      min_r   <= RESET_MIN;
      max_r   <= RESET_MAX;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_index == REG_MIN) begin
        min_r <= cfg_data;
      end
      if (cfg_valid && cfg_index == REG_MAX) begin
        max_r <= cfg_data;
      end
    end
  end

  // A positive span always fits in 32 bits, so the borrow bit is not kept.
  assign span      = max_r - min_r;
  assign range_err = $signed(max_r) <= $signed(min_r);

  always_comb begin
    launch_nxt.valid = draw_fire;
    launch_nxt.rem   = '0;
    launch_nxt.dvd   = lcg_next;
    launch_nxt.dsr   = span;
    launch_nxt.lo    = min_r;
    launch_nxt.err   = range_err;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      launch_r.rem <= launch_nxt.rem;
      launch_r.dvd <= launch_nxt.dvd;
      launch_r.dsr <= launch_nxt.dsr;
      launch_r.lo  <= launch_nxt.lo;
      launch_r.err <= launch_nxt.err;
    end
    if (!rst_n) begin
      launch_r.valid <= 1'b0;
    end else if (adv) begin
      launch_r.valid <= launch_nxt.valid;
    end
  end

  assign chain[0] = launch_r;

  // Remainder chain: each cell retires one dividend bit, MSB first.
  for (genvar i = 0; i < CELL_N; i++) begin : g_cell
    lcg_rg_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .beat_in  (chain[i]),
      .beat_out (chain[i+1])
    );
  end

  // After a full set of rotations the dividend is back to the raw state.
  always_comb begin
    if (chain[CELL_N].err) begin
      last_value = chain[CELL_N].lo;
    end else begin
      last_value = chain[CELL_N].lo + chain[CELL_N].rem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= chain[CELL_N].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_value_r <= last_value;
      out_raw_r   <= chain[CELL_N].dvd;
      out_err_r   <= chain[CELL_N].err;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_value       = $signed(out_value_r);
  assign out_raw_state   = out_raw_r;
  assign out_range_error = out_err_r;

endmodule

### hdl/lcg_rg_cell.sv
`timescale 1ns / 1ps

module lcg_rg_cell
  import lcg_rg_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  div_beat_t beat_in,
  output div_beat_t beat_out
);

  logic [WORD_W:0]   shifted;
  logic [WORD_W:0]   diff;
  logic [WORD_W-1:0] rem_nxt;
  div_beat_t         beat_r;

  // Shift in the next dividend bit, subtract the span if it fits.
  always_comb begin
    shifted = {beat_in.rem, beat_in.dvd[WORD_W-1]};
    diff    = shifted - {1'b0, beat_in.dsr};
    if (shifted >= {1'b0, beat_in.dsr}) begin
      rem_nxt = diff[WORD_W-1:0];
    end else begin
      rem_nxt = shifted[WORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      beat_r.rem <= rem_nxt;
      beat_r.dvd <= {beat_in.dvd[WORD_W-2:0], beat_in.dvd[WORD_W-1]};
      beat_r.dsr <= beat_in.dsr;
      beat_r.lo  <= beat_in.lo;
      beat_r.err <= beat_in.err;
    end
    if (!rst_n) begin
      beat_r.valid <= 1'b0;
    end else if (adv) begin
      beat_r.valid <= beat_in.valid;
    end
  end

  assign beat_out = beat_r;

endmodule

### hdl/lcg_rg_chk.sv
`timescale 1ns / 1ps

module lcg_rg_chk
  import lcg_rg_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     in_draw,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [WORD_W-1:0] out_value,
  input logic        [WORD_W-1:0] out_raw_state,
  input logic                     out_range_error,
  input logic                     cfg_valid,
  input logic                     cfg_ready,
  input logic        [INDEX_W-1:0] cfg_index,
  input logic        [WORD_W-1:0] cfg_data
);

  // Input side stalls exactly when a result is stuck.
  a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not track output stall");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) &&
      $stable(out_raw_state) && $stable(out_range_error))
    else $error("stalled result changed");

  a_cfg_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind lcg_range_generator_top lcg_rg_chk u_lcg_rg_chk (.*);

### tb/tb_lcg_range_generator_top.sv
`timescale 1ns / 1ps

module tb_lcg_range_generator_top;
  import lcg_rg_pkg::*;

  // Unused register index: writes here must leave the generator alone.
  localparam logic [INDEX_W-1:0] REG_NONE = 2'd3;
  // Pipeline depth from the top level plus margin; used to let dropped beats
  // flush before a register write and at the end of the run.
  localparam int FLUSH_CYCLES = 40;

  typedef struct packed {
    logic signed [WORD_W-1:0] value;
    logic        [WORD_W-1:0] raw_state;
    logic                     range_error;
  } draw_result_t;

  typedef enum logic [1:0] {ROW_DRAW, ROW_DROP, ROW_WRITE} row_kind_t;

  // One directed step: a draw, a dropped request or a register write. Rows
  // marked typed carry the value and range flag read straight off the spec;
  // the raw state always comes from the generator model below.
  typedef struct packed {
    row_kind_t          kind;
    logic [INDEX_W-1:0] index;
    logic [WORD_W-1:0]  data;
    logic               typed;
    logic [WORD_W-1:0]  value;
    logic               range_error;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic in_draw;
  logic out_valid;
  logic out_ready;
  logic signed [WORD_W-1:0] out_value;
  logic [WORD_W-1:0] out_raw_state;
  logic out_range_error;
  logic cfg_valid;
  logic cfg_ready;
  logic [INDEX_W-1:0] cfg_index;
  logic [WORD_W-1:0] cfg_data;

  // Generator model: state and bounds as the block should hold them.
  logic [WORD_W-1:0] gen_state;
  logic [WORD_W-1:0] bound_lo;
  logic [WORD_W-1:0] bound_hi;

  draw_result_t pending_results[$];

  bit no_idle;
  int fail_count;
  int n_draws;
  int n_drops;
  int n_writes;
  int n_empty_range;

  stim_row_t directed_rows [0:24] = '{
    '{ROW_DRAW,  REG_SEED, 32'h0,         1'b1, 32'd6780,      1'b0}, // first draw after reset
    '{ROW_DRAW,  REG_SEED, 32'h0,         1'b0, 32'h0,         1'b0},
    '{ROW_DROP,  REG_SEED, 32'h0,         1'b0, 32'h0,         1'b0},
    '{ROW_DRAW,  REG_SEED, 32'h0,         1'b0, 32'h0,         1'b0},
    '{ROW_WRITE, REG_SEED, 32'h0,         1'b0, 32'h0,         1'b0},
    '{ROW_DRAW,  REG_SEED, 32'h0,         1'b1, 32'd4989,      1'b0}, // seed 0: state = add term
    '{ROW_WRITE, REG_NONE, 32'hDEAD_BEEF, 1'b0, 32'h0,         1'b0},
    '{ROW_DRAW,  REG_SEED, 32'h0,         1'b0, 32'h0,         1'b0},
    '{ROW_WRITE, REG_MIN,  32'h8000_0000, 1'b0, 32'h0,         1'b0},
    '{ROW_WRITE, REG_MAX,  32'h7FFF_FFFF, 1'b0, 32'h0,         1'b0}, // widest span
    '{ROW_DRAW,  REG_SEED, 32'h0,         1'b0, 32'h0,         1'b0},
    '{ROW_WRITE, REG_SEED, 32'hFFFF_FFFF, 1'b0, 32'h0,         1'b0},
    '{ROW_DRAW,  REG_SEED, 32'h0,         1'b0, 32'h0,         1'b0},
    '{ROW_DROP,  REG_SEED, 32'h0,         1'b0, 32'h0,         1'b0},
    '{ROW_WRITE, REG_MAX,  32'h8000_0000, 1'b0, 32'h0,         1'b0}, // max == min
    '{ROW_DRAW,  REG_SEED, 32'h0,         1'b1, 32'h8000_0000, 1'b1},
    '{ROW_WRITE, REG_MIN,  32'h7FFF_FFFF, 1'b0, 32'h0,         1'b0}, // max far below min
    '{ROW_DRAW,  REG_SEED, 32'h0,         1'b1, 32'h7FFF_FFFF, 1'b1},
    '{ROW_WRITE, REG_MAX,  32'h0,         1'b0, 32'h0,         1'b0},
    '{ROW_DRAW,  REG_SEED, 32'h0,         1'b1, 32'h7FFF_FFFF, 1'b1},
    '{ROW_WRITE, REG_MIN,  32'hFFFF_FFFB, 1'b0, 32'h0,         1'b0}, // [-5, 0)
    '{ROW_DRAW,  REG_SEED, 32'h0,         1'b0, 32'h0,         1'b0},
    '{ROW_WRITE, REG_MAX,  32'hFFFF_FFFC, 1'b0, 32'h0,         1'b0}, // span of one
    '{ROW_DRAW,  REG_SEED, 32'h0,         1'b1, 32'hFFFF_FFFB, 1'b0},
    '{ROW_DRAW,  REG_SEED, 32'h0,         1'b1, 32'hFFFF_FFFB, 1'b0}
  };

  lcg_range_generator_top uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_draw        (in_draw),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_value      (out_value),
    .out_raw_state  (out_raw_state),
    .out_range_error(out_range_error),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  // Advance the model state one step and reduce it into [lo, hi). The span
  // is formed at 64 bits so the full signed range never overflows.
  function automatic draw_result_t advance_and_reduce();
    draw_result_t r;
    longint lo;
    longint hi;
    longint span;
    gen_state = gen_state * LCG_MUL + LCG_ADD;
    lo = longint'($signed(bound_lo));
    hi = longint'($signed(bound_hi));
    r.raw_state = gen_state;
    r.range_error = (hi <= lo);
    if (r.range_error) begin
      r.value = bound_lo;
    end else begin
      span = hi - lo;
      r.value = 32'(lo + (longint'({32'd0, gen_state}) % span));
    end
    return r;
  endfunction

  // Mostly back-to-back, some short gaps, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic log_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t mismatch: %s", $realtime, msg);
  endtask

  // Offer one request beat; hold it until taken, then record what it owes.
  task automatic offer_draw(input logic want_draw, input logic typed,
                            input logic [WORD_W-1:0] typed_value,
                            input logic typed_err);
    draw_result_t r;
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_draw  <= want_draw;
    do @(posedge clk); while (!in_ready);
    if (want_draw) begin
      r = advance_and_reduce();
      if (typed) begin
        r.value = typed_value;
        r.range_error = typed_err;
      end
      if (r.range_error) n_empty_range++;
      pending_results.insert(pending_results.size(), r);
      n_draws++;
    end else begin
      n_drops++;
    end
  endtask

  // Drop the request line, wait for every owed result, then flush the pipe.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (FLUSH_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [WORD_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SEED: gen_state = data;
      REG_MIN:  bound_lo  = data;
      REG_MAX:  bound_hi  = data;
      default:  ;
    endcase
    n_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Result sink: alternate ready bursts with stalls of random length.
  initial begin : result_sink
    int stall;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Compare every accepted result beat against the oldest owed result.
  always @(posedge clk) begin : result_check
    draw_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        log_failure($sformatf("unexpected beat: value %0d raw %h err %b",
                              out_value, out_raw_state, out_range_error));
      end else begin
        want = pending_results.pop_front();
        if (out_value !== want.value || out_raw_state !== want.raw_state ||
            out_range_error !== want.range_error) begin
          log_failure($sformatf("value %0d/%0d raw %h/%h err %b/%b (expected/actual)",
                                want.value, out_value, want.raw_state, out_raw_state,
                                want.range_error, out_range_error));
        end
      end
    end
  end

  initial begin : stimulus
    stim_row_t row;
    logic [WORD_W-1:0] lo_pick;
    logic [WORD_W-1:0] hi_pick;
    int mode;
    int sent;
    int wait_cnt;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_draw   <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_SEED;
    cfg_data  <= '0;
    no_idle = 1'b0;
    gen_state = RESET_SEED;
    bound_lo  = RESET_MIN;
    bound_hi  = RESET_MAX;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed walk: reset values, seed reload, ignored index, bound extremes,
    // empty ranges and the single-value range.
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      case (row.kind)
        ROW_WRITE: begin
          settle();
          write_reg(row.index, row.data);
        end
        ROW_DROP: offer_draw(1'b0, 1'b0, '0, 1'b0);
        default:  offer_draw(1'b1, row.typed, row.value, row.range_error);
      endcase
    end

    // Random phases: new bounds (and often a new seed) each phase, then a run
    // of draws with a few dropped requests mixed in.
    for (int phase = 0; phase < 8; phase++) begin
      settle();
      lo_pick = $urandom;
      hi_pick = $urandom;
      mode = (phase < 6) ? phase : $urandom_range(0, 5);
      case (mode)
        0: begin
          lo_pick = '0;
          hi_pick = $urandom_range(1, 16);
        end
        1: begin
          lo_pick = 32'h8000_0000;
          hi_pick = 32'h7FFF_FFFF;
        end
        2: ;  // fully random bounds, empty about half the time
        3: hi_pick = lo_pick;
        4: begin
          // power-of-two span placed so max cannot wrap
          lo_pick = $signed(lo_pick) >>> 1;
          hi_pick = lo_pick + (32'd1 << $urandom_range(0, 30));
        end
        default: begin
          lo_pick = 32'h8000_0000 + $urandom_range(0, 255);
          hi_pick = $urandom & 32'h7FFF_FFFF;
        end
      endcase
      if ($urandom_range(0, 1)) begin
        write_reg(REG_MIN, lo_pick);
        write_reg(REG_MAX, hi_pick);
      end else begin
        write_reg(REG_MAX, hi_pick);
        write_reg(REG_MIN, lo_pick);
      end
      case ($urandom_range(0, 3))
        0: write_reg(REG_SEED, '0);
        1: write_reg(REG_SEED, 32'hFFFF_FFFF);
        2: write_reg(REG_SEED, $urandom);
        default: ;  // keep the running state
      endcase
      if ($urandom_range(0, 2) == 0) write_reg(REG_NONE, $urandom);
      no_idle = (phase % 4 == 3);
      sent = 0;
      while (sent < 100) begin
        if ($urandom_range(0, 9) == 0) begin
          offer_draw(1'b0, 1'b0, '0, 1'b0);
        end else begin
          offer_draw(1'b1, 1'b0, '0, 1'b0);
          sent++;
        end
      end
      no_idle = 1'b0;
    end

    // Drain: wait for the owed results, then give stray beats time to show.
    in_valid <= 1'b0;
    wait_cnt = 0;
    while (pending_results.size() != 0 && wait_cnt < 20000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (FLUSH_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      log_failure($sformatf("%0d results never arrived", pending_results.size()));
    end

    $display("covered %0d draws, %0d dropped requests, %0d register writes",
             n_draws, n_drops, n_writes);
    $display("%0d draws hit an empty range; %0d failures", n_empty_range, fail_count);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #5_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
